[rtl/pidht_pkg.sv]
// Shared types and constants for the peer identifier hash table.
package pidht_pkg;

  localparam int KEY_W        = 64;
  localparam int IP_W         = 32;
  localparam int PORT_W       = 16;
  localparam int OP_W         = 2;
  // Sum of sixteen key bytes: at most 16 * 255 = 4080, which needs 12 bits.
  localparam int SUM_W        = 12;
  localparam int MAX_SUM      = 4080;
  localparam int IN_TDATA_W   = 176;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 48;
  localparam int OUT_TUSER_W  = 2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_BASE,
    ST_RD,
    ST_CMP,
    ST_ACT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } slot_t;

endpackage

[rtl/peer_id_hash_table.sv]
// Hash table mapping a 128-bit peer identifier to an IPv4 address and port. The bucket of a
// key is the sum of its sixteen bytes modulo BUCKETS, and each bucket holds WAYS slots in a
// slot memory of BUCKETS*WAYS words with one write port and one registered read port. One
// input word at a time is processed: the byte sum is formed in the accept cycle, a shared
// compare-and-subtract unit reduces it in state ST_MOD, state ST_BASE forms the bucket
// address, then each way passes through ST_RD (memory read) and ST_CMP (key compare), and
// state ST_ACT writes back and loads the result once the result register is free. A clear
// sweeps the slot memory one word per cycle over all BUCKETS*WAYS words (2044 by default)
// before its result word appears. The same sweep runs after reset, and no input word is
// accepted until it has finished. The result register lets the next input word be accepted
// while a result still waits downstream.
module peer_id_hash_table #(
  parameter int BUCKETS = 511,
  parameter int WAYS    = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // key_high [63:0], key_low [127:64], ip_address [159:128], port_number [175:160]
  input  logic [pidht_pkg::IN_TDATA_W-1:0]    s_tdata,
  // operation [1:0]
  input  logic [pidht_pkg::IN_TUSER_W-1:0]    s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // result_ip [31:0], result_port [47:32]
  output logic [pidht_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // found [0], status [1]
  output logic [pidht_pkg::OUT_TUSER_W-1:0]   m_tuser
);

  localparam int SLOTS     = BUCKETS * WAYS;
  localparam int ADDR_W    = $clog2(SLOTS);
  localparam int BIDX_W    = $clog2(BUCKETS);
  localparam int BKT_W     = $clog2(BUCKETS + 1);
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MOD_Q     = pidht_pkg::MAX_SUM / BUCKETS + 1;
  localparam int MOD_STEPS = (MOD_Q > 1) ? $clog2(MOD_Q) : 1;
  localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int CMP_W     = ((pidht_pkg::SUM_W > BKT_W) ? pidht_pkg::SUM_W : BKT_W)
                             + MOD_STEPS;

  pidht_pkg::state_t state, state_next;

  pidht_pkg::slot_t mem [SLOTS];
  pidht_pkg::slot_t rd_data;
  pidht_pkg::slot_t mem_wdata;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  pidht_pkg::op_t                 op_r;
  logic [pidht_pkg::KEY_W-1:0]    key_high_r;
  logic [pidht_pkg::KEY_W-1:0]    key_low_r;
  logic [pidht_pkg::IP_W-1:0]     ip_r;
  logic [pidht_pkg::PORT_W-1:0]   port_r;

  logic [pidht_pkg::SUM_W-1:0]    rem;
  logic [STEP_W-1:0]              mod_step;
  logic [ADDR_W-1:0]              cur_addr;
  logic [WAY_W-1:0]               way_cnt;
  logic                           clear_reply;

  logic                           hit;
  logic                           free;
  logic [ADDR_W-1:0]              hit_addr;
  logic [ADDR_W-1:0]              free_addr;
  logic [pidht_pkg::IP_W-1:0]     hit_ip;
  logic [pidht_pkg::PORT_W-1:0]   hit_port;

  logic                           found_r;
  logic                           status_r;
  logic [pidht_pkg::IP_W-1:0]     res_ip;
  logic [pidht_pkg::PORT_W-1:0]   res_port;

  logic [8:0]                     pair [8];
  logic [pidht_pkg::SUM_W-1:0]    byte_sum;
  logic [CMP_W-1:0]               dshift;
  logic [CMP_W-1:0]               rem_ext;
  logic                           rem_ge;
  logic [pidht_pkg::SUM_W-1:0]    rem_sub;
  logic [ADDR_W-1:0]              bucket_base;

  logic                           accept;
  logic                           out_free;
  logic                           act_go;
  logic                           clear_last;
  logic                           key_match;

  // Byte sum: eight independent byte pairs, then eight narrow accumulations.
  always_comb begin
    byte_sum = '0;
    for (int i = 0; i < 8; i++) begin
      pair[i] = 9'(s_tdata[8*i +: 8]) + 9'(s_tdata[pidht_pkg::KEY_W + 8*i +: 8]);
    end
    for (int i = 0; i < 8; i++) begin
      byte_sum = byte_sum + pidht_pkg::SUM_W'(pair[i]);
    end
  end

  // Shared compare-and-subtract unit for the modulo reduction.
  assign dshift  = CMP_W'(BUCKETS) << mod_step;
  assign rem_ext = CMP_W'(rem);
  assign rem_ge  = (rem_ext >= dshift);
  assign rem_sub = pidht_pkg::SUM_W'(rem_ext - dshift);

  assign bucket_base = ADDR_W'(rem[BIDX_W-1:0]) * ADDR_W'(WAYS);
  assign key_match   = (rd_data.key_high == key_high_r) && (rd_data.key_low == key_low_r);
  assign clear_last  = (cur_addr == ADDR_W'(SLOTS - 1));
  assign out_free    = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      pidht_pkg::ST_CLEAR: begin
        if (clear_last) begin
          state_next = clear_reply ? pidht_pkg::ST_ACT : pidht_pkg::ST_IDLE;
        end
      end
      pidht_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (pidht_pkg::op_t'(s_tuser[1:0]) == pidht_pkg::OP_CLEAR)
                       ? pidht_pkg::ST_CLEAR : pidht_pkg::ST_MOD;
        end
      end
      pidht_pkg::ST_MOD: begin
        if (mod_step == '0) begin
          state_next = pidht_pkg::ST_BASE;
        end
      end
      pidht_pkg::ST_BASE: state_next = pidht_pkg::ST_RD;
      pidht_pkg::ST_RD:   state_next = pidht_pkg::ST_CMP;
      pidht_pkg::ST_CMP: begin
        state_next = (way_cnt == WAY_W'(WAYS - 1)) ? pidht_pkg::ST_ACT : pidht_pkg::ST_RD;
      end
      pidht_pkg::ST_ACT: begin
        if (out_free) begin
          state_next = pidht_pkg::ST_IDLE;
        end
      end
      default: state_next = pidht_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    act_go    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = '0;
    unique case (state)
      pidht_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      pidht_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      pidht_pkg::ST_ACT: begin
        act_go         = out_free;
        mem_waddr      = hit ? hit_addr : free_addr;
        mem_wdata      = '{valid: (op_r == pidht_pkg::OP_INSERT), key_high: key_high_r,
                           key_low: key_low_r, ip: ip_r, port: port_r};
        if (out_free) begin
          mem_we = ((op_r == pidht_pkg::OP_INSERT) && (hit || free)) ||
                   ((op_r == pidht_pkg::OP_DELETE) && hit);
        end
      end
      default: begin
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pidht_pkg::ST_CLEAR;
      cur_addr    <= '0;
      clear_reply <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (act_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        pidht_pkg::ST_CLEAR: begin
          if (!clear_last) begin
            cur_addr <= cur_addr + ADDR_W'(1);
          end
        end
        pidht_pkg::ST_IDLE: begin
          if (accept) begin
            cur_addr    <= '0;
            clear_reply <= 1'b1;
          end
        end
        pidht_pkg::ST_BASE: begin
          cur_addr <= bucket_base;
        end
        pidht_pkg::ST_CMP: begin
          cur_addr <= cur_addr + ADDR_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Operands, search results and the result register carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= pidht_pkg::op_t'(s_tuser[1:0]);
      key_high_r <= s_tdata[0 +: pidht_pkg::KEY_W];
      key_low_r  <= s_tdata[pidht_pkg::KEY_W +: pidht_pkg::KEY_W];
      ip_r       <= s_tdata[2*pidht_pkg::KEY_W +: pidht_pkg::IP_W];
      port_r     <= s_tdata[2*pidht_pkg::KEY_W + pidht_pkg::IP_W +: pidht_pkg::PORT_W];
      rem        <= byte_sum;
      mod_step   <= STEP_W'(MOD_STEPS - 1);
      way_cnt    <= '0;
      hit        <= 1'b0;
      free       <= 1'b0;
    end
    if (state == pidht_pkg::ST_MOD) begin
      if (rem_ge) begin
        rem <= rem_sub;
      end
      mod_step <= mod_step - STEP_W'(1);
    end
    if (state == pidht_pkg::ST_CMP) begin
      way_cnt <= way_cnt + WAY_W'(1);
      if (rd_data.valid) begin
        if (!hit && key_match) begin
          hit      <= 1'b1;
          hit_addr <= cur_addr;
          hit_ip   <= rd_data.ip;
          hit_port <= rd_data.port;
        end
      end else if (!free) begin
        free      <= 1'b1;
        free_addr <= cur_addr;
      end
    end
    if (act_go) begin
      found_r  <= hit;
      res_ip   <= hit ? hit_ip : '0;
      res_port <= hit ? hit_port : '0;
      status_r <= ((op_r == pidht_pkg::OP_INSERT) && !hit && !free)
                  ? pidht_pkg::STATUS_FULL : pidht_pkg::STATUS_DONE;
    end
  end

  assign m_tdata = {res_port, res_ip};
  assign m_tuser = {status_r, found_r};

  // The slot memory is written only by the clearing sweep or the write-back step.
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == pidht_pkg::ST_CLEAR || state == pidht_pkg::ST_ACT))
    else $error("slot memory written outside sweep or write-back");

  // The modulo reduction must leave a valid bucket index.
  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    (state == pidht_pkg::ST_BASE) |-> (rem < BUCKETS))
    else $error("bucket index out of range after reduction");

  // A full bucket is reported only for a key that was not found.
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> !m_tuser[0])
    else $error("full status together with found");

  // Reset starts the clearing sweep with no result word pending.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> (state == pidht_pkg::ST_CLEAR && !m_tvalid && !s_tready))
    else $error("reset did not start the clearing sweep");

endmodule

[tb/peer_id_hash_table_tb.sv]
// Self-checking stream testbench for the peer identifier hash table.
module peer_id_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_BUCKETS    = 511;
  localparam int TBL_WAYS       = 4;
  localparam int TBL_SLOTS      = TBL_BUCKETS * TBL_WAYS;
  localparam int RANDOM_WORDS   = 1980;
  localparam int HOT_BUCKETS    = 6;
  localparam int POOL_KEYS      = 36;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    pidht_pkg::op_t               op;
    logic [pidht_pkg::KEY_W-1:0]  key_high;
    logic [pidht_pkg::KEY_W-1:0]  key_low;
    logic [pidht_pkg::IP_W-1:0]   ip;
    logic [pidht_pkg::PORT_W-1:0] port;
  } request_t;

  typedef struct {
    logic                         found;
    logic [pidht_pkg::IP_W-1:0]   ip;
    logic [pidht_pkg::PORT_W-1:0] port;
    logic                         status;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [pidht_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic [pidht_pkg::IN_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [pidht_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [pidht_pkg::OUT_TUSER_W-1:0] m_tuser;

  request_t request_q[$];
  reply_t   reply_q[$];
  request_t pending;

  // Shadow copy of the slot memory.
  bit                           shadow_valid[TBL_SLOTS];
  logic [pidht_pkg::KEY_W-1:0]  shadow_key_high[TBL_SLOTS];
  logic [pidht_pkg::KEY_W-1:0]  shadow_key_low[TBL_SLOTS];
  logic [pidht_pkg::IP_W-1:0]   shadow_ip[TBL_SLOTS];
  logic [pidht_pkg::PORT_W-1:0] shadow_port[TBL_SLOTS];

  int words_total = 0;
  int words_in = 0;
  int errors = 0;
  int hits = 0;
  int full_refusals = 0;
  int clears = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int idle_cycles = 0;

  peer_id_hash_table #(
    .BUCKETS(TBL_BUCKETS),
    .WAYS   (TBL_WAYS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int bucket_for(logic [pidht_pkg::KEY_W-1:0] kh,
                                    logic [pidht_pkg::KEY_W-1:0] kl);
    int sum;
    int i;
    sum = 0;
    for (i = 0; i < 8; i++) begin
      sum += int'(kh[8*i +: 8]) + int'(kl[8*i +: 8]);
    end
    return sum % TBL_BUCKETS;
  endfunction

  // Builds a random 128-bit key whose byte sum lands in the given bucket.
  function automatic logic [127:0] key_in_bucket(int bucket);
    logic [127:0] k;
    int total;
    int lo;
    int hi;
    int b;
    int i;
    total = bucket + TBL_BUCKETS
            * $urandom_range((pidht_pkg::MAX_SUM - bucket) / TBL_BUCKETS, 0);
    for (i = 0; i < 16; i++) begin
      lo = total - 255 * (15 - i);
      if (lo < 0) lo = 0;
      hi = (total > 255) ? 255 : total;
      b = $urandom_range(hi, lo);
      k[8*i +: 8] = b[7:0];
      total -= b;
    end
    return k;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  task automatic queue_word(pidht_pkg::op_t op, logic [127:0] key,
                            logic [pidht_pkg::IP_W-1:0] ip,
                            logic [pidht_pkg::PORT_W-1:0] port);
    request_t rq;
    rq.op       = op;
    rq.key_high = key[63:0];
    rq.key_low  = key[127:64];
    rq.ip       = ip;
    rq.port     = port;
    request_q.push_back(rq);
    words_total++;
  endtask

  // Applies one accepted word to the shadow table and records the reply it must produce.
  task automatic table_apply(request_t rq);
    reply_t r;
    int base;
    int s;
    int hit;
    int free_slot;
    int w;
    r.found  = 1'b0;
    r.ip     = '0;
    r.port   = '0;
    r.status = pidht_pkg::STATUS_DONE;
    if (rq.op == pidht_pkg::OP_CLEAR) begin
      for (s = 0; s < TBL_SLOTS; s++) shadow_valid[s] = 1'b0;
      clears++;
    end else begin
      base = bucket_for(rq.key_high, rq.key_low) * TBL_WAYS;
      hit = -1;
      free_slot = -1;
      for (w = 0; w < TBL_WAYS; w++) begin
        s = base + w;
        if (shadow_valid[s]) begin
          if (hit < 0 && shadow_key_high[s] == rq.key_high && shadow_key_low[s] == rq.key_low)
            hit = s;
        end else if (free_slot < 0) begin
          free_slot = s;
        end
      end
      if (hit >= 0) begin
        r.found = 1'b1;
        r.ip    = shadow_ip[hit];
        r.port  = shadow_port[hit];
        hits++;
      end
      if (rq.op == pidht_pkg::OP_INSERT) begin
        if (hit >= 0) begin
          shadow_ip[hit]   = rq.ip;
          shadow_port[hit] = rq.port;
        end else if (free_slot >= 0) begin
          shadow_valid[free_slot]    = 1'b1;
          shadow_key_high[free_slot] = rq.key_high;
          shadow_key_low[free_slot]  = rq.key_low;
          shadow_ip[free_slot]       = rq.ip;
          shadow_port[free_slot]     = rq.port;
        end else begin
          r.status = pidht_pkg::STATUS_FULL;
          full_refusals++;
        end
      end else if (rq.op == pidht_pkg::OP_DELETE && hit >= 0) begin
        shadow_valid[hit] = 1'b0;
      end
    end
    reply_q.push_back(r);
  endtask

  // Input side: holds each word until it is taken, then idles for a random gap.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        table_apply(pending);
        words_in++;
        send_gap = pick_gap(send_calm);
        if ($urandom_range(149, 0) == 0) send_calm = !send_calm;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          pending = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {pending.port, pending.ip, pending.key_low, pending.key_high};
          s_tuser <= pending.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each result word against the oldest expected reply.
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          $error("result word with no operation outstanding");
          errors++;
        end else begin
          exp_r = reply_q.pop_front();
          if (m_tuser[0] !== exp_r.found) begin
            $error("found: expected %0d, got %0d", exp_r.found, m_tuser[0]);
            errors++;
          end
          if (m_tdata[31:0] !== exp_r.ip) begin
            $error("result_ip: expected %h, got %h", exp_r.ip, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[47:32] !== exp_r.port) begin
            $error("result_port: expected %h, got %h", exp_r.port, m_tdata[47:32]);
            errors++;
          end
          if (m_tuser[1] !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_tuser[1]);
            errors++;
          end
        end
        recv_gap = pick_gap(recv_calm);
        if ($urandom_range(149, 0) == 0) recv_calm = !recv_calm;
      end else if (!recv_calm && recv_gap == 0 && $urandom_range(19, 0) == 0) begin
        recv_gap = pick_gap(recv_calm);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [127:0] key_zero;
    logic [127:0] key_ones;
    logic [127:0] crowd[5];
    logic [127:0] key_pool[POOL_KEYS];
    int hot[HOT_BUCKETS];
    int n;
    int r;
    logic [127:0] key;
    pidht_pkg::op_t op;

    key_zero = '0;
    key_ones = '1;
    for (n = 0; n < 5; n++) crowd[n] = key_in_bucket(TBL_BUCKETS - 1);

    // Directed: empty table, update of a present key, a bucket filled past its ways,
    // deletes of absent and present keys, reuse of the freed way, and a clear.
    queue_word(pidht_pkg::OP_LOOKUP, key_zero, 32'hFFFF_FFFF, 16'hFFFF);
    queue_word(pidht_pkg::OP_INSERT, key_zero, 32'hFFFF_FFFF, 16'hFFFF);
    queue_word(pidht_pkg::OP_LOOKUP, key_zero, '0, '0);
    queue_word(pidht_pkg::OP_INSERT, key_zero, '0, '0);
    queue_word(pidht_pkg::OP_LOOKUP, key_zero, '0, '0);
    queue_word(pidht_pkg::OP_INSERT, key_ones, $urandom, 16'h8001);
    queue_word(pidht_pkg::OP_DELETE, key_in_bucket(7), '0, '0);
    for (n = 0; n < 4; n++) begin
      queue_word(pidht_pkg::OP_INSERT, crowd[n], $urandom, 16'($urandom));
    end
    queue_word(pidht_pkg::OP_INSERT, crowd[4], $urandom, 16'($urandom));
    queue_word(pidht_pkg::OP_DELETE, crowd[1], '0, '0);
    queue_word(pidht_pkg::OP_LOOKUP, crowd[1], '0, '0);
    queue_word(pidht_pkg::OP_INSERT, crowd[4], $urandom, 16'($urandom));
    queue_word(pidht_pkg::OP_LOOKUP, crowd[4], '0, '0);
    queue_word(pidht_pkg::OP_DELETE, crowd[4], '0, '0);
    queue_word(pidht_pkg::OP_DELETE, crowd[4], '0, '0);
    queue_word(pidht_pkg::OP_CLEAR, key_ones, 32'hFFFF_FFFF, 16'hFFFF);
    queue_word(pidht_pkg::OP_LOOKUP, key_zero, '0, '0);
    queue_word(pidht_pkg::OP_LOOKUP, key_ones, '0, '0);

    // A few crowded buckets with more keys than ways keep hits and full buckets frequent.
    for (n = 0; n < HOT_BUCKETS; n++) hot[n] = $urandom_range(TBL_BUCKETS - 1, 0);
    for (n = 0; n < POOL_KEYS; n++) key_pool[n] = key_in_bucket(hot[n % HOT_BUCKETS]);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      r = $urandom_range(99, 0);
      if (r < 2) begin
        queue_word(pidht_pkg::OP_CLEAR, {$urandom, $urandom, $urandom, $urandom},
                   $urandom, 16'($urandom));
      end else if (r < 10) begin
        op = pidht_pkg::op_t'($urandom_range(2, 0));
        queue_word(op, {$urandom, $urandom, $urandom, $urandom}, $urandom, 16'($urandom));
      end else begin
        key = key_pool[$urandom_range(POOL_KEYS - 1, 0)];
        r = $urandom_range(99, 0);
        if (r < 45) op = pidht_pkg::OP_INSERT;
        else if (r < 75) op = pidht_pkg::OP_LOOKUP;
        else op = pidht_pkg::OP_DELETE;
        queue_word(op, key, $urandom, 16'($urandom));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (words_in < words_total) @(posedge clk);
    while (reply_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations over crowded and random buckets, %0d table clears.",
             words_total, clears);
    $display("Keys found: %0d, inserts refused on a full bucket: %0d.", hits, full_refusals);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
